// ===== rtl/core/ucs2_hex_to_utf8_assert.svh =====
// Assertion macros used by the port checker of the hex to UTF-8 converter.
`ifndef UCS2_HEX_TO_UTF8_ASSERT_SVH
`define UCS2_HEX_TO_UTF8_ASSERT_SVH

// Property checked on every clock edge, suspended while reset is high.
`define UCS2_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define UCS2_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/ucs2_pkg.sv =====
// Shared types and constants of the UCS-2 hex to UTF-8 converter.
`default_nettype none

package ucs2_pkg;

  // Default number of entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_CHAR   = 2'd1,
    ST_BAD_LENGTH = 2'd2
  } status_t;

  // One queued job: up to three bytes that the back end sends in order.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] last_idx;
    status_t    status;
    logic       done;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/ucs2_front.sv =====
// Front end: takes hex characters, assembles code units and queues UTF-8 jobs.
`default_nettype none

module ucs2_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  hex_char,
  input  wire logic        text_end,
  input  wire logic        q_full,
  output logic             push,
  output ucs2_pkg::job_t   job
);
  import ucs2_pkg::*;

  logic [1:0]  nibble_count, nibble_count_next;
  logic [11:0] partial_unit, partial_unit_next;
  logic        error_skip, error_skip_next;
  logic        accept;
  logic        digit_ok;
  logic [3:0]  digit;
  logic [15:0] unit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign unit     = {partial_unit, digit};

  // Decode one ASCII hex digit.
  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (hex_char inside {[8'h30:8'h39]}) begin
      digit = hex_char[3:0];
    end else if (hex_char inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      digit = hex_char[3:0] + 4'd9;
    end else begin
      digit_ok = 1'b0;
    end
  end

  // Classify the character and build the job it causes, if any.
  always_comb begin
    nibble_count_next = nibble_count;
    partial_unit_next = partial_unit;
    error_skip_next   = error_skip;
    push              = 1'b0;
    job               = '{b0: 8'h00, b1: 8'h00, b2: 8'h00, last_idx: 2'd0,
                          status: ST_OK, done: 1'b0};
    if (accept) begin
      if (error_skip) begin
        if (text_end) begin
          nibble_count_next = 2'd0;
          partial_unit_next = 12'h000;
          error_skip_next   = 1'b0;
        end
      end else if (text_end && nibble_count != 2'd3) begin
        push              = 1'b1;
        job.status        = ST_BAD_LENGTH;
        job.done          = 1'b1;
        nibble_count_next = 2'd0;
        partial_unit_next = 12'h000;
      end else if (!digit_ok) begin
        push              = 1'b1;
        job.status        = ST_BAD_CHAR;
        job.done          = text_end;
        nibble_count_next = 2'd0;
        partial_unit_next = 12'h000;
        error_skip_next   = !text_end;
      end else if (nibble_count != 2'd3) begin
        partial_unit_next = {partial_unit[7:0], digit};
        nibble_count_next = nibble_count + 2'd1;
      end else begin
        // A full unit: encode as one, two or three bytes.
        push     = 1'b1;
        job.done = text_end;
        if (unit[15:7] == 9'd0) begin
          job.b0       = {1'b0, unit[6:0]};
          job.last_idx = 2'd0;
        end else if (unit[15:11] == 5'd0) begin
          job.b0       = {3'b110, unit[10:6]};
          job.b1       = {2'b10, unit[5:0]};
          job.last_idx = 2'd1;
        end else begin
          job.b0       = {4'b1110, unit[15:12]};
          job.b1       = {2'b10, unit[11:6]};
          job.b2       = {2'b10, unit[5:0]};
          job.last_idx = 2'd2;
        end
        nibble_count_next = 2'd0;
        partial_unit_next = 12'h000;
      end
    end
  end

  // Character state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_count <= 2'd0;
      partial_unit <= 12'h000;
      error_skip   <= 1'b0;
    end else begin
      nibble_count <= nibble_count_next;
      partial_unit <= partial_unit_next;
      error_skip   <= error_skip_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ucs2_queue.sv =====
// Small register queue of jobs between the front and back ends.
`default_nettype none

module ucs2_queue #(
  parameter int DEPTH = ucs2_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ucs2_pkg::job_t  wr_job,
  output logic                 full,
  input  wire logic            pop,
  output ucs2_pkg::job_t       head,
  output logic                 empty
);
  import ucs2_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ucs2_back.sv =====
// Back end: sends the bytes of each queued job through an output register.
`default_nettype none

module ucs2_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ucs2_pkg::job_t  head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           utf8_byte,
  output logic                 run_last,
  output ucs2_pkg::status_t    status,
  output logic                 text_done
);
  import ucs2_pkg::*;

  logic [1:0] byte_idx;
  logic       load;
  logic       take;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = !out_valid || out_ready;
  assign take    = load && !empty;
  assign is_last = (byte_idx == head.last_idx);
  assign pop     = take && is_last;

  // Pick the byte of the head job that goes out next.
  always_comb begin
    case (byte_idx)
      2'd0:    sel_byte = head.b0;
      2'd1:    sel_byte = head.b1;
      2'd2:    sel_byte = head.b2;
      default: sel_byte = 8'h00;
    endcase
  end

  // Output valid and byte position within the job.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= 2'd0;
    end else if (load) begin
      out_valid <= !empty;
      if (take) begin
        byte_idx <= is_last ? 2'd0 : byte_idx + 2'd1;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (take) begin
      utf8_byte <= sel_byte;
      run_last  <= is_last;
      status    <= head.status;
      text_done <= is_last && head.done;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ucs2_hex_to_utf8.sv =====
// Top level of the UCS-2 hex text to UTF-8 converter.
//
//   channel  | direction | tdata         | tlast     | tuser
//   s_axis   | in        | hex_char      | text_end  | -
//   m_axis   | out       | utf8_byte     | run_last  | status, text_done
//
// One character word is accepted per cycle while the job queue has room.
// A character that completes a unit or raises an error queues one job; the
// back end sends one byte word per cycle while the output is ready; the first
// word of a result passes through a queue entry and then the output register.
// Four characters give at most three bytes, keeping the rate at one character
// per cycle. A stalled output only stops input once all QUEUE_DEPTH job entries
// are taken. Synchronous reset clears the character state, queue and out_valid.
`default_nettype none

module ucs2_hex_to_utf8 #(
  parameter int QUEUE_DEPTH = ucs2_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] hex_char
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] utf8_byte
  output logic             m_axis_tlast,
  output logic [2:0]       m_axis_tuser    // [1:0] status, [2] text_done
);
  import ucs2_pkg::*;

  job_t    wr_job;
  job_t    head;
  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_empty;
  status_t out_status;
  logic    out_done;

  // Character intake and classification.
  ucs2_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .hex_char (s_axis_tdata),
    .text_end (s_axis_tlast),
    .q_full   (q_full),
    .push     (push),
    .job      (wr_job)
  );

  // Job queue between the two ends.
  ucs2_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty)
  );

  // Byte output.
  ucs2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .utf8_byte (m_axis_tdata),
    .run_last  (m_axis_tlast),
    .status    (out_status),
    .text_done (out_done)
  );

  assign m_axis_tuser = {out_done, out_status};

endmodule

`default_nettype wire

// ===== rtl/core/ucs2_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`default_nettype none

`include "ucs2_hex_to_utf8_assert.svh"

module ucs2_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [2:0]  m_axis_tuser
);

  logic        out_done;
  logic        out_error;
  logic        out_mid;
  logic        out_stall;
  logic [11:0] out_word;

  // Conditions seen on the output word.
  assign out_done  = m_axis_tvalid && m_axis_tuser[2];
  assign out_error = m_axis_tvalid && (m_axis_tuser[1:0] != 2'd0);
  assign out_mid   = m_axis_tvalid && !m_axis_tlast;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tdata, m_axis_tlast, m_axis_tuser};

  // A word that closes the text must also close its run.
  `UCS2_ASSERT(a_done_is_last, out_done |-> m_axis_tlast, "text_done without tlast")

  // Error words carry a zero byte and end their run.
  `UCS2_ASSERT(a_error_word, out_error |-> (m_axis_tdata == 8'h00) && m_axis_tlast, "bad error word")

  // A byte that is not the last of its unit is a lead or continuation byte.
  `UCS2_ASSERT(a_multi_byte, out_mid |-> m_axis_tdata[7] && (m_axis_tuser == 3'd0), "bad byte in unit")

  // A stalled output word holds still.
  `UCS2_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled word changed")

endmodule

bind ucs2_hex_to_utf8 ucs2_port_checker u_checker (.*);

`default_nettype wire

// ===== bench/ucs2_checker.sv =====
// Checker for the hex to UTF-8 converter: watches both streams, predicts and compares.
`default_nettype none

module ucs2_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  input  wire logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] hex_char
  input  wire logic       s_axis_tlast,
  input  wire logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  input  wire logic [7:0] m_axis_tdata,   // [7:0] utf8_byte
  input  wire logic       m_axis_tlast,
  input  wire logic [2:0] m_axis_tuser,   // [1:0] status, [2] text_done
  output int              mismatches,
  output int              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ucs2_pkg::*;

  // One output word as the converter should send it.
  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_last;
    status_t    status;
    logic       text_done;
  } utf8_word_t;

  // Converter state as predicted from the accepted characters.
  logic [1:0]  digits_held;
  logic [11:0] held_digits;
  logic        skipping;
  utf8_word_t  expected_words[$];

  // Returns {valid, value} for one ASCII character.
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return {1'b1, ch[3:0]};
    if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
      return {1'b1, ch[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic void clear_text_state();
    digits_held = 2'd0;
    held_digits = 12'd0;
    skipping    = 1'b0;
  endfunction

  function automatic void push_word(input logic [7:0] value, input logic last_flag,
                                    input status_t code, input logic done_flag);
    utf8_word_t w;
    w.utf8_byte = value;
    w.run_last  = last_flag;
    w.status    = code;
    w.text_done = done_flag;
    expected_words.push_back(w);
  endfunction

  // Works out the words that one accepted character causes.
  function automatic void convert_char(input logic [7:0] ch, input logic end_flag);
    logic [4:0]  dig;
    logic [15:0] code_unit;
    dig = hex_digit(ch);
    // After an error everything up to the end of the text is dropped silently.
    if (skipping) begin
      if (end_flag) clear_text_state();
      return;
    end
    // A text that ends before its last unit is complete is a length error,
    // even when the final character itself is not a hex digit.
    if (end_flag && digits_held != 2'd3) begin
      push_word(8'h00, 1'b1, ST_BAD_LENGTH, 1'b1);
      clear_text_state();
      return;
    end
    if (!dig[4]) begin
      push_word(8'h00, 1'b1, ST_BAD_CHAR, end_flag);
      clear_text_state();
      skipping = !end_flag;
      return;
    end
    if (digits_held != 2'd3) begin
      held_digits = {held_digits[7:0], dig[3:0]};
      digits_held = digits_held + 2'd1;
      return;
    end
    // Fourth digit: encode the completed unit in one, two or three bytes.
    code_unit = {held_digits, dig[3:0]};
    if (code_unit <= 16'h007F) begin
      push_word(code_unit[7:0], 1'b1, ST_OK, end_flag);
    end else if (code_unit <= 16'h07FF) begin
      push_word(8'hC0 | {3'd0, code_unit[10:6]}, 1'b0, ST_OK, 1'b0);
      push_word(8'h80 | {2'd0, code_unit[5:0]}, 1'b1, ST_OK, end_flag);
    end else begin
      push_word(8'hE0 | {4'd0, code_unit[15:12]}, 1'b0, ST_OK, 1'b0);
      push_word(8'h80 | {2'd0, code_unit[11:6]}, 1'b0, ST_OK, 1'b0);
      push_word(8'h80 | {2'd0, code_unit[5:0]}, 1'b1, ST_OK, end_flag);
    end
    clear_text_state();
  endfunction

  // Predict on accepted characters, compare on accepted output words.
  always @(posedge clk) begin
    utf8_word_t got;
    utf8_word_t want;
    if (rst) begin
      clear_text_state();
      expected_words.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) convert_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.utf8_byte = m_axis_tdata;
        got.run_last  = m_axis_tlast;
        got.status    = status_t'(m_axis_tuser[1:0]);
        got.text_done = m_axis_tuser[2];
        if (expected_words.size() == 0) begin
          mismatches <= mismatches + 1;
          $display("%0t: unexpected output word: byte %02h last %0b status %0d done %0b",
                   $time, got.utf8_byte, got.run_last, got.status, got.text_done);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            $display("%0t: output word mismatch: expected byte %02h last %0b status %0d done %0b",
                     $time, want.utf8_byte, want.run_last, want.status, want.text_done);
            $display("%0t:                         actual byte %02h last %0b status %0d done %0b",
                     $time, got.utf8_byte, got.run_last, got.status, got.text_done);
          end
        end
      end
      outstanding <= expected_words.size();
    end
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Top of the hex to UTF-8 converter bench: clock, reset, stimulus and verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 130;
  localparam int CALM_AFTER   = 105;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] hex_char
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] utf8_byte
  logic       m_axis_tlast;
  logic [2:0] m_axis_tuser;           // [1:0] status, [2] text_done
  int         mismatches;
  int         outstanding;

  bit         idling_on = 1'b1;
  bit         hold_request = 1'b0;
  int         random_items;
  int         quiet_cycles;
  logic [7:0] text_chars[$];

  ucs2_hex_to_utf8 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  ucs2_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_hex(input logic [7:0] ch);
    return (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h46) ||
           (ch >= 8'h61 && ch <= 8'h66);
  endfunction

  // Appends the four hex characters of one code unit, case chosen per digit.
  task automatic add_unit(input logic [15:0] code_unit);
    logic [3:0] nib;
    for (int i = 3; i >= 0; i--) begin
      nib = code_unit[i*4 +: 4];
      if (nib < 4'd10) text_chars.push_back(8'h30 + nib);
      else if ($urandom_range(0, 1)) text_chars.push_back(8'h41 + nib - 8'd10);
      else text_chars.push_back(8'h61 + nib - 8'd10);
    end
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
  endtask

  // Offers one character word and holds it until the converter takes it.
  task automatic send_word(input logic [7:0] ch, input logic last_flag);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last_flag;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Sends the built text with tlast on its final character. Characters after
  // an illegal one are skipped by the converter and are not counted.
  task automatic send_text();
    bit skipped;
    skipped = 1'b0;
    for (int i = 0; i < text_chars.size(); i++) begin
      send_word(text_chars[i], i == text_chars.size() - 1);
      if (!skipped) random_items++;
      if (!is_hex(text_chars[i])) skipped = 1'b1;
    end
    text_chars.delete();
  endtask

  function automatic logic [15:0] pick_unit();
    logic [15:0] corners[7] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                16'h0800, 16'hD800, 16'hFFFF};
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      3: return corners[$urandom_range(0, 6)];
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Builds one random text: mostly well formed, some with a bad character,
  // a missing tail, or nothing but random bytes.
  task automatic build_random_text();
    int         kind;
    int         units;
    logic [7:0] bad;
    kind  = $urandom_range(0, 9);
    units = $urandom_range(1, 4);
    if (kind == 9) begin
      repeat ($urandom_range(1, 6)) text_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (units) add_unit(pick_unit());
      if (kind == 7) begin
        do bad = 8'($urandom_range(0, 255)); while (is_hex(bad));
        text_chars[$urandom_range(0, text_chars.size() - 1)] = bad;
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 3)) void'(text_chars.pop_back());
      end
    end
  endtask

  // Output side: random stalls, and once a long hold-off so the queue fills.
  initial begin
    wait (!rst);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Watchdog on cycles where neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Size boundaries of the encoding, mixed letter case, largest unit.
    add_str("007F008007ffFFFF");
    send_text();
    // A text of one digit is a length error.
    add_str("1");
    send_text();
    // Illegal first character, then skipping up to the end.
    add_str("Gx0");
    send_text();
    // Illegal final character on the fourth digit, a zero byte.
    add_str("abc");
    text_chars.push_back(8'h00);
    send_text();

    // Random texts; the output side holds off for a long stretch first.
    random_items = 0;
    hold_request = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= CALM_AFTER) idling_on = 1'b0;
      build_random_text();
      send_text();
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
